// ===== design/frb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frb_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int LEN_OVERHEAD    = 2;
  localparam logic [7:0] HEADER_RESET = 8'h52;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [5:0] frame_length;
    logic       last_of_run;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/frb_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface frb_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/length_prefixed_frame_receiver_top.sv =====
// Input: one byte per cycle while hunting, reading the length or storing payload,
// unless the result channel stalls. Error and empty-frame words are registered
// and appear in the cycle after the byte that causes them. Payload readout: byte
// by byte, store read registered, then loaded into output reg (waits on a stall).
// Input is held off during readout. Reset (rst, sync) returns to hunting, header 0x52.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver_top #(
  parameter int FRAME_BYTES = frb_pkg::FRAME_BYTES_DEF,
  localparam int PAYLOAD_MAX = FRAME_BYTES - frb_pkg::LEN_OVERHEAD,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  frb_chan_if.sink        rx_ch,
  frb_chan_if.source      res_ch
);

  import frb_pkg::*;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  frb_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_ch     (rx_ch),
    .res_ch    (res_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  frb_store #(
    .DEPTH (PAYLOAD_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== design/frb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frb_store #(
  parameter int DEPTH = frb_pkg::FRAME_BYTES_DEF - frb_pkg::LEN_OVERHEAD,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/frb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frb_ctrl #(
  parameter int FRAME_BYTES = frb_pkg::FRAME_BYTES_DEF,
  localparam int PAYLOAD_MAX = FRAME_BYTES - frb_pkg::LEN_OVERHEAD,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1,
  localparam int CW = $clog2(PAYLOAD_MAX + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  frb_chan_if.sink           rx_ch,
  frb_chan_if.source         res_ch,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [7:0]    rd_data
);

  import frb_pkg::*;

  localparam logic [8:0] LIMIT    = 9'(FRAME_BYTES);
  localparam logic [8:0] OVERHEAD = 9'(LEN_OVERHEAD);

  state_t     state, state_next;
  logic [7:0] header;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] ridx, ridx_next;
  logic       res_valid, res_valid_next;
  out_word_t  res_word, res_word_next;

  logic       rx_ready;
  logic       rx_fire;
  logic       out_free;
  logic [7:0] rx_b;
  logic       oversize;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] ridx_inc;

  assign rx_b     = rx_ch.payload.rx_byte;
  assign out_free = !res_valid || res_ch.ready;
  assign rx_ready = (state != ST_EMIT_RD) && (state != ST_EMIT_WR) && out_free;
  assign rx_fire  = rx_ch.valid && rx_ready;
  assign oversize = ({1'b0, rx_b} + OVERHEAD) > LIMIT;
  assign cnt_inc  = cnt + CW'(1);
  assign ridx_inc = ridx + CW'(1);

  assign rx_ch.ready    = rx_ready;
  assign res_ch.valid   = res_valid;
  assign res_ch.payload = res_word;

  assign wr_addr = cnt[AW-1:0];
  assign wr_data = rx_b;
  assign rd_addr = ridx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HUNT;
      header    <= HEADER_RESET;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        header <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    len      <= len_next;
    cnt      <= cnt_next;
    ridx     <= ridx_next;
    res_word <= res_word_next;
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    cnt_next       = cnt;
    ridx_next      = ridx;
    res_valid_next = res_valid && !res_ch.ready;
    res_word_next  = res_word;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    case (state)
      ST_HUNT: begin
        if (rx_fire && (rx_b == header)) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        if (rx_fire) begin
          if (oversize) begin
            state_next     = ST_HUNT;
            res_valid_next = 1'b1;
            res_word_next  = '{kind: KIND_OVERSIZE, payload_byte: 8'd0,
                               frame_length: 6'd0, last_of_run: 1'b1};
          end else begin
            len_next   = rx_b[CW-1:0];
            cnt_next   = '0;
            state_next = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (rx_fire) begin
          wr_en    = 1'b1;
          cnt_next = cnt_inc;
          if (cnt_inc >= len) begin
            if (len == '0) begin
              state_next     = ST_HUNT;
              res_valid_next = 1'b1;
              res_word_next  = '{kind: KIND_EMPTY, payload_byte: 8'd0,
                                 frame_length: 6'd0, last_of_run: 1'b1};
            end else begin
              ridx_next  = '0;
              state_next = ST_EMIT_RD;
            end
          end
        end
      end
      ST_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          res_word_next  = '{kind: KIND_PAYLOAD, payload_byte: rd_data,
                             frame_length: 6'(len), last_of_run: (ridx_inc == len)};
          if (ridx_inc == len) begin
            state_next = ST_HUNT;
          end else begin
            ridx_next  = ridx_inc;
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  // length byte over the limit yields an error word next cycle
  a_oversize_report: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && (state == ST_LEN) && oversize) |=>
      (res_valid && (res_word.kind == KIND_OVERSIZE) && res_word.last_of_run))
    else $error("oversize length not reported");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_WR) |-> (ridx < len))
    else $error("read index beyond frame length");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD) |-> (len != '0))
    else $error("emitting an empty frame");

  a_no_write_while_emit: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT_RD) || (state == ST_EMIT_WR)) |-> (!wr_en && !rx_ready))
    else $error("input taken during payload readout");

endmodule

`default_nettype wire
